FILE: sv/frs_pkg.sv
package frs_pkg;

  localparam int unsigned SCORE_W  = 15;
  localparam int unsigned NUM_W    = 31;
  localparam int unsigned DEN_W    = 16;
  localparam int unsigned WEIGHT_W = 9;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SCORE_W-1:0] FULL_SCORE = 15'd25600;
  localparam logic [SCORE_W-1:0] CAP_SCORE  = 15'd25344;

  typedef enum logic [2:0] {
    REG_FLAME_THR    = 3'd0,
    REG_WEIGHT_Z     = 3'd1,
    REG_WEIGHT_TREND = 3'd2,
    REG_WEIGHT_LEVEL = 3'd3,
    REG_WEIGHT_FLAME = 3'd4,
    REG_TREND_DANGER = 3'd5,
    REG_LEVEL_SAFE   = 3'd6,
    REG_LEVEL_DANGER = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'b01,
    SEL_FULL = 2'b10,
    SEL_DIV  = 2'b00
  } map_sel_t;

  typedef struct packed {
    logic [15:0]         flame_thr;
    logic [WEIGHT_W-1:0] weight_z;
    logic [WEIGHT_W-1:0] weight_trend;
    logic [WEIGHT_W-1:0] weight_level;
    logic [WEIGHT_W-1:0] weight_flame;
    logic [14:0]         trend_danger;
    logic [11:0]         level_safe;
    logic [11:0]         level_danger;
  } cfg_t;

  // One division job: select code, numerator and divisor.
  typedef struct packed {
    map_sel_t         sel;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_job_t;

  typedef struct packed {
    logic               confirmed;
    logic [SCORE_W-1:0] zmap;
    div_job_t           trend;
    div_job_t           level;
    div_job_t           flame;
  } item_t;

  // One restoring division step: returns the new remainder and the quotient bit.
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                              input logic nbit,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic [DEN_W:0] d;
    t = {rem, nbit};
    d = {1'b0, den};
    if (t >= d) begin
      t = t - d;
      div_step = {t[DEN_W-1:0], 1'b1};
    end else begin
      div_step = {t[DEN_W-1:0], 1'b0};
    end
  endfunction

  function automatic logic [SCORE_W-1:0] map_pick(input map_sel_t sel,
                                                  input logic [SCORE_W-1:0] q);
    logic [SCORE_W-1:0] r;
    r = q;
    unique case (sel)
      SEL_ZERO: r = '0;
      SEL_FULL: r = FULL_SCORE;
      SEL_DIV:  r = q;
      default:  r = q;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/fire_risk_score_fusion.sv
// Channel  Direction  Handshake              Payload
// in_      input      start, busy            z_score, gas_rate, gas_level, flame_ticks, flame_seen
// out_     output     out_valid strobe       risk_score, fire_confirmed
// cfg_     input      cfg_valid, cfg_ready   cfg_index, cfg_data
// One word is accepted per cycle while busy is low.
// The pipeline holds three 15-step restoring dividers, one quotient bit per stage.
// Reset is synchronous and active low; it clears all valid bits and loads register defaults.
// The result strobe lasts one cycle; the receiver cannot stall, so the pipeline never stops.
module fire_risk_score_fusion import frs_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_z_score,
  input  logic [15:0] in_gas_rate,
  input  logic [11:0] in_gas_level,
  input  logic [15:0] in_flame_ticks,
  input  logic        in_flame_seen,
  output logic        out_valid,
  output logic [14:0] out_risk_score,
  output logic        out_fire_confirmed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  logic  accept;
  logic  front_valid;
  item_t front_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flame_thr    <= 16'd10;
      cfg_r.weight_z     <= 9'd64;
      cfg_r.weight_trend <= 9'd64;
      cfg_r.weight_level <= 9'd64;
      cfg_r.weight_flame <= 9'd64;
      cfg_r.trend_danger <= 15'd256;
      cfg_r.level_safe   <= 12'd300;
      cfg_r.level_danger <= 12'd1500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FLAME_THR:    cfg_r.flame_thr    <= cfg_data;
        REG_WEIGHT_Z:     cfg_r.weight_z     <= cfg_data[8:0];
        REG_WEIGHT_TREND: cfg_r.weight_trend <= cfg_data[8:0];
        REG_WEIGHT_LEVEL: cfg_r.weight_level <= cfg_data[8:0];
        REG_WEIGHT_FLAME: cfg_r.weight_flame <= cfg_data[8:0];
        REG_TREND_DANGER: cfg_r.trend_danger <= cfg_data[14:0];
        REG_LEVEL_SAFE:   cfg_r.level_safe   <= cfg_data[11:0];
        REG_LEVEL_DANGER: cfg_r.level_danger <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  frs_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .z_score     (in_z_score),
    .gas_rate    (in_gas_rate),
    .gas_level   (in_gas_level),
    .flame_ticks (in_flame_ticks),
    .flame_seen  (in_flame_seen),
    .item_valid  (front_valid),
    .item        (front_item)
  );

  frs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  frs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (q_valid),
    .in_item       (q_item),
    .res_valid     (out_valid),
    .res_score     (out_risk_score),
    .res_confirmed (out_fire_confirmed)
  );

endmodule

FILE: sv/frs_front.sv
module frs_front import frs_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [15:0] z_score,
  input  logic [15:0] gas_rate,
  input  logic [11:0] gas_level,
  input  logic [15:0] flame_ticks,
  input  logic        flame_seen,
  output logic        item_valid,
  output item_t       item
);

  localparam logic [17:0] TWO = 18'(18'd2 << FRACTION_BITS);
  localparam logic [17:0] SIX = 18'(18'd6 << FRACTION_BITS);

  logic               valid_r;
  item_t              item_r, item_nxt;
  logic [17:0]        u;
  logic [14:0]        diff;
  logic [12:0]        coef;
  logic [SCORE_W-1:0] base;
  logic [27:0]        prod;
  logic [27:0]        zsum;
  logic [SCORE_W-1:0] zmap;
  logic [14:0]        rate;
  logic [11:0]        lvl_diff;
  logic [11:0]        lvl_span;

  always_comb begin
    u = {3'b000, z_score[14:0]};
    if (u <= TWO) begin
      diff = z_score[14:0];
      coef = 13'd1280;
      base = '0;
    end else if (u <= SIX) begin
      diff = 15'(u - TWO);
      coef = 13'd4480;
      base = 15'd2560;
    end else begin
      diff = 15'(u - SIX);
      coef = 13'd1280;
      base = 15'd20480;
    end
    prod = 28'(diff) * 28'(coef);
    zsum = 28'(base) + (prod >> FRACTION_BITS);
    if (z_score[15] || z_score == 16'd0) begin
      zmap = '0;
    end else if (u <= TWO && zsum > 28'd2560) begin
      zmap = 15'd2560;
    end else if (zsum > 28'(FULL_SCORE)) begin
      zmap = FULL_SCORE;
    end else begin
      zmap = zsum[SCORE_W-1:0];
    end
  end

  always_comb begin
    rate     = gas_rate[14:0];
    lvl_diff = gas_level - cfg.level_safe;
    lvl_span = cfg.level_danger - cfg.level_safe;

    item_nxt.confirmed = flame_seen && (flame_ticks >= cfg.flame_thr);
    item_nxt.zmap      = zmap;

    item_nxt.trend.num = NUM_W'(rate) * NUM_W'(FULL_SCORE);
    item_nxt.trend.den = {1'b0, cfg.trend_danger};
    if (gas_rate[15] || gas_rate == 16'd0) begin
      item_nxt.trend.sel = SEL_ZERO;
    end else if (cfg.trend_danger == 15'd0 || rate >= cfg.trend_danger) begin
      item_nxt.trend.sel = SEL_FULL;
    end else begin
      item_nxt.trend.sel = SEL_DIV;
    end

    item_nxt.level.num = NUM_W'(lvl_diff) * NUM_W'(FULL_SCORE);
    item_nxt.level.den = DEN_W'(lvl_span);
    if (gas_level <= cfg.level_safe) begin
      item_nxt.level.sel = SEL_ZERO;
    end else if (gas_level >= cfg.level_danger) begin
      item_nxt.level.sel = SEL_FULL;
    end else begin
      item_nxt.level.sel = SEL_DIV;
    end

    item_nxt.flame.num = NUM_W'(flame_ticks) * NUM_W'(FULL_SCORE);
    item_nxt.flame.den = cfg.flame_thr;
    if (flame_ticks == 16'd0) begin
      item_nxt.flame.sel = SEL_ZERO;
    end else if (flame_ticks >= cfg.flame_thr) begin
      item_nxt.flame.sel = SEL_FULL;
    end else begin
      item_nxt.flame.sel = SEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: sv/frs_queue.sv
module frs_queue import frs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t      mem_r [QUEUE_DEPTH];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  // The back end never stalls, so every queued word leaves in the next cycle.
  assign do_pop  = (count_r != 2'd0);
  assign do_push = push && (count_r != 2'(QUEUE_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
    end
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  assign full      = (count_r == 2'(QUEUE_DEPTH));
  assign pop_valid = do_pop;
  assign pop_item  = mem_r[rptr_r];

endmodule

FILE: sv/frs_back.sv
module frs_back import frs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               res_valid,
  output logic [SCORE_W-1:0] res_score,
  output logic               res_confirmed
);

  localparam int unsigned STEPS = SCORE_W;

  logic               valid_r [STEPS+1];
  item_t              item_r  [STEPS+1];
  logic [DEN_W-1:0]   rem_r   [STEPS+1][3];
  logic [SCORE_W-1:0] q_r     [STEPS+1][3];

  // Stage 0 loads the remainder with the numerator bits above the quotient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
    item_r[0]    <= in_item;
    rem_r[0][0]  <= in_item.trend.num[NUM_W-1:STEPS];
    rem_r[0][1]  <= in_item.level.num[NUM_W-1:STEPS];
    rem_r[0][2]  <= in_item.flame.num[NUM_W-1:STEPS];
    q_r[0][0]    <= '0;
    q_r[0][1]    <= '0;
    q_r[0][2]    <= '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int unsigned BIT = STEPS - 1 - k;
    logic [DEN_W:0] s0, s1, s2;

    always_comb begin
      s0 = div_step(rem_r[k][0], item_r[k].trend.num[BIT], item_r[k].trend.den);
      s1 = div_step(rem_r[k][1], item_r[k].level.num[BIT], item_r[k].level.den);
      s2 = div_step(rem_r[k][2], item_r[k].flame.num[BIT], item_r[k].flame.den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else begin
        valid_r[k+1] <= valid_r[k];
      end
      item_r[k+1]   <= item_r[k];
      rem_r[k+1][0] <= s0[DEN_W:1];
      rem_r[k+1][1] <= s1[DEN_W:1];
      rem_r[k+1][2] <= s2[DEN_W:1];
      q_r[k+1][0]   <= {q_r[k][0][SCORE_W-2:0], s0[0]};
      q_r[k+1][1]   <= {q_r[k][1][SCORE_W-2:0], s1[0]};
      q_r[k+1][2]   <= {q_r[k][2][SCORE_W-2:0], s2[0]};
    end
  end

  localparam int unsigned PROD_W = SCORE_W + WEIGHT_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic              pvalid_r, pconf_r;
  logic [PROD_W-1:0] p_r [4];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-9:0]  scaled;
  logic              ovalid_r, oconf_r;
  logic [SCORE_W-1:0] oscore_r, oscore_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= valid_r[STEPS];
    end
    pconf_r <= item_r[STEPS].confirmed;
    p_r[0]  <= PROD_W'(item_r[STEPS].zmap) * PROD_W'(cfg.weight_z);
    p_r[1]  <= PROD_W'(map_pick(item_r[STEPS].trend.sel, q_r[STEPS][0]))
               * PROD_W'(cfg.weight_trend);
    p_r[2]  <= PROD_W'(map_pick(item_r[STEPS].level.sel, q_r[STEPS][1]))
               * PROD_W'(cfg.weight_level);
    p_r[3]  <= PROD_W'(map_pick(item_r[STEPS].flame.sel, q_r[STEPS][2]))
               * PROD_W'(cfg.weight_flame);
  end

  always_comb begin
    sum    = SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(p_r[2]) + SUM_W'(p_r[3]);
    scaled = sum[SUM_W-1:8];
    if (pconf_r) begin
      oscore_nxt = FULL_SCORE;
    end else if (scaled > (SUM_W-8)'(CAP_SCORE)) begin
      oscore_nxt = CAP_SCORE;
    end else begin
      oscore_nxt = scaled[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= pvalid_r;
    end
    oconf_r  <= pconf_r;
    oscore_r <= oscore_nxt;
  end

  assign res_valid     = ovalid_r;
  assign res_score     = oscore_r;
  assign res_confirmed = oconf_r;

endmodule

FILE: sv/frs_checker.sv
module frs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [14:0] out_risk_score,
  input logic        out_fire_confirmed,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_confirmed_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fire_confirmed |-> out_risk_score == 15'd25600)
    else $error("confirmed result without full score");

  a_unconfirmed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fire_confirmed |-> out_risk_score <= 15'd25344)
    else $error("unconfirmed score above cap");

  // Each accepted word must raise the result strobe; it is sampled at the next edge.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##20 out_valid)
    else $error("result missing at fixed latency");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind fire_risk_score_fusion frs_checker u_frs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_risk_score     (out_risk_score),
  .out_fire_confirmed (out_fire_confirmed),
  .cfg_valid          (cfg_valid),
  .cfg_ready          (cfg_ready)
);

FILE: verif/frs_checker.sv
module frs_scoreboard import frs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_z_score,
  input  logic [15:0] in_gas_rate,
  input  logic [11:0] in_gas_level,
  input  logic [15:0] in_flame_ticks,
  input  logic        in_flame_seen,
  input  logic        out_valid,
  input  logic [14:0] out_risk_score,
  input  logic        out_fire_confirmed,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0] score;
    logic        confirmed;
  } risk_t;

  localparam longint unsigned FULL = 25600;
  localparam longint unsigned CAP  = 25344;

  cfg_t  regs;
  risk_t risk_q[$];

  function automatic longint unsigned zscore_map(logic signed [15:0] z);
    longint unsigned u, s;
    if (z <= 0) return 0;
    u = longint'(z);
    if (u <= 512) begin
      s = (u * 1280) >> 8;
      return (s > 2560) ? 2560 : s;
    end
    if (u <= 1536) return 2560 + (((u - 512) * 4480) >> 8);
    s = 20480 + (((u - 1536) * 1280) >> 8);
    return (s > FULL) ? FULL : s;
  endfunction

  function automatic longint unsigned trend_map(logic signed [15:0] r);
    longint unsigned s;
    if (r <= 0) return 0;
    if (regs.trend_danger == 0) return FULL;
    s = (longint'(r) * FULL) / regs.trend_danger;
    return (s > FULL) ? FULL : s;
  endfunction

  function automatic longint unsigned level_map(logic [11:0] raw);
    if (raw <= regs.level_safe) return 0;
    if (raw >= regs.level_danger) return FULL;
    return ((raw - regs.level_safe) * FULL) / (regs.level_danger - regs.level_safe);
  endfunction

  function automatic longint unsigned flame_map(logic [15:0] ticks);
    if (ticks == 0) return 0;
    if (ticks >= regs.flame_thr) return FULL;
    return (longint'(ticks) * FULL) / regs.flame_thr;
  endfunction

  function automatic risk_t fuse(logic [15:0] z, logic [15:0] r, logic [11:0] lvl,
                                 logic [15:0] ticks, logic seen);
    risk_t res;
    longint unsigned acc;
    if (seen && ticks >= regs.flame_thr) begin
      res.score = 15'(FULL);
      res.confirmed = 1'b1;
      return res;
    end
    acc = zscore_map(z) * regs.weight_z + trend_map(r) * regs.weight_trend
        + level_map(lvl) * regs.weight_level + flame_map(ticks) * regs.weight_flame;
    acc = acc >> 8;
    if (acc > CAP) acc = CAP;
    res.score = 15'(acc);
    res.confirmed = 1'b0;
    return res;
  endfunction

  assign pending = risk_q.size();

  always @(posedge clk) begin
    risk_t want;
    if (!rst_n) begin
      regs.flame_thr    <= 16'd10;
      regs.weight_z     <= 9'd64;
      regs.weight_trend <= 9'd64;
      regs.weight_level <= 9'd64;
      regs.weight_flame <= 9'd64;
      regs.trend_danger <= 15'd256;
      regs.level_safe   <= 12'd300;
      regs.level_danger <= 12'd1500;
      risk_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FLAME_THR:    regs.flame_thr    <= cfg_data;
          REG_WEIGHT_Z:     regs.weight_z     <= cfg_data[8:0];
          REG_WEIGHT_TREND: regs.weight_trend <= cfg_data[8:0];
          REG_WEIGHT_LEVEL: regs.weight_level <= cfg_data[8:0];
          REG_WEIGHT_FLAME: regs.weight_flame <= cfg_data[8:0];
          REG_TREND_DANGER: regs.trend_danger <= cfg_data[14:0];
          REG_LEVEL_SAFE:   regs.level_safe   <= cfg_data[11:0];
          REG_LEVEL_DANGER: regs.level_danger <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (start && !busy)
        risk_q.push_back(fuse(in_z_score, in_gas_rate, in_gas_level,
                              in_flame_ticks, in_flame_seen));
      if (out_valid) begin
        if (risk_q.size() == 0) begin
          $display("%0t: unexpected word, actual score %0d confirmed %0d",
                   $time, out_risk_score, out_fire_confirmed);
          fail_count <= fail_count + 1;
        end else begin
          want = risk_q.pop_front();
          if (want.score !== out_risk_score || want.confirmed !== out_fire_confirmed) begin
            $display("%0t: mismatch, expected score %0d confirmed %0d, actual %0d %0d",
                     $time, want.score, want.confirmed, out_risk_score, out_fire_confirmed);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: verif/tb.sv
module tb import frs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_z_score = '0;
  logic [15:0] in_gas_rate = '0;
  logic [11:0] in_gas_level = '0;
  logic [15:0] in_flame_ticks = '0;
  logic        in_flame_seen = 1'b0;
  logic        out_valid;
  logic [14:0] out_risk_score;
  logic        out_fire_confirmed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          word_count = 0;
  bit          no_idle = 1'b0;
  logic [15:0] cur_thr = 16'd10;
  logic [14:0] cur_tdr = 15'd256;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fire_risk_score_fusion u_top (.*);
  frs_scoreboard u_chk (.*);

  task automatic send_word(logic [15:0] z, logic [15:0] r, logic [11:0] lvl,
                           logic [15:0] ticks, logic seen);
    int gap;
    if (!no_idle && $urandom_range(99) < 6) begin
      start = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_z_score = z;
    in_gas_rate = r;
    in_gas_level = lvl;
    in_flame_ticks = ticks;
    in_flame_seen = seen;
    do @(posedge clk); while (busy);
    word_count++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    if (!no_idle && $urandom_range(99) < 6) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Configuration changes only once the pipeline has drained.
  task automatic set_phase(int ph);
    logic [15:0] v[8];
    while (pending != 0) @(negedge clk);
    case (ph)
      0: v = '{16'd10, 16'd64, 16'd64, 16'd64, 16'd64, 16'd256, 16'd300, 16'd1500};
      1: v = '{16'd0, 16'd256, 16'd256, 16'd256, 16'd256, 16'd0, 16'd4095, 16'd0};
      2: v = '{16'd65535, 16'd511, 16'd511, 16'd511, 16'd511, 16'd32767, 16'd0, 16'd4095};
      3: v = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd2000, 16'd2000};
      default: begin
        v[0] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 60));
        for (int k = 1; k < 5; k++) v[k] = 16'($urandom_range(0, 511));
        v[5] = $urandom_range(0, 1) ? 16'($urandom_range(0, 32767)) : 16'($urandom_range(1, 1024));
        v[6] = 16'($urandom_range(0, 4095));
        v[7] = 16'($urandom_range(0, 4095));
      end
    endcase
    for (int k = 0; k < 8; k++) write_reg(reg_idx_t'(k), v[k]);
    cur_thr = v[0];
    cur_tdr = v[5][14:0];
  endtask

  task automatic random_word();
    logic [15:0] z, r, ticks;
    z = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2200));
    r = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2 * cur_tdr + 2));
    ticks = $urandom_range(0, 1) ? 16'($urandom)
          : 16'($urandom_range(0, (cur_thr > 30000) ? 65535 : 2 * cur_thr + 2));
    send_word(z, r, 12'($urandom), ticks, 1'($urandom));
  endtask

  initial begin
    int guard;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    // Directed: field extremes and map breakpoints at reset settings.
    send_word(16'h0000, 16'h0000, 12'd0, 16'd0, 1'b0);
    send_word(16'h7fff, 16'h7fff, 12'd4095, 16'hffff, 1'b0);
    send_word(16'h8000, 16'h8000, 12'd0, 16'd0, 1'b0);
    send_word(16'd512, 16'd1, 12'd300, 16'd9, 1'b1);
    send_word(16'd513, 16'd256, 12'd301, 16'd1, 1'b0);
    send_word(16'd1536, 16'd255, 12'd1500, 16'd10, 1'b1);
    send_word(16'd1537, 16'd257, 12'd1499, 16'd0, 1'b1);
    send_word(16'd6656, 16'hffff, 12'd900, 16'd11, 1'b0);
    send_word(16'hffff, 16'd0, 12'd4095, 16'hffff, 1'b1);
    send_word(16'd1, 16'd100, 12'd700, 16'd5, 1'b0);
    set_phase(1);
    // Zero threshold and zero danger rate, danger not above safe.
    send_word(16'd0, 16'd1, 12'd4095, 16'd0, 1'b1);
    send_word(16'd0, 16'd1, 12'd4094, 16'd1, 1'b0);
    send_word(16'h7fff, 16'h7fff, 12'd4095, 16'd0, 1'b0);
    set_phase(2);
    send_word(16'h7fff, 16'h7fff, 12'd4095, 16'hfffe, 1'b1);
    send_word(16'h7fff, 16'h7fff, 12'd4095, 16'hffff, 1'b1);
    for (int ph = 0; ph < 9; ph++) begin
      set_phase(ph);
      no_idle = (ph == 4);
      for (int n = 0; n < 70; n++) random_word();
    end
    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
    repeat (25) @(negedge clk);
    $display("Sent %0d words over nine register settings, including zero and full-scale", 
             word_count);
    $display("thresholds, weights and level windows; %0d words outstanding.", pending);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: sim.f
sv/frs_pkg.sv
sv/frs_front.sv
sv/frs_queue.sv
sv/frs_back.sv
sv/fire_risk_score_fusion.sv
sv/frs_checker.sv
verif/frs_checker.sv
verif/tb.sv
